// ----- hdl/gni_pkg.sv -----
package gni_pkg;

  localparam int IDX_W      = 20;
  localparam int SLOT_W     = 3;
  localparam int NB_COUNT   = 8;
  localparam int CFG_W      = 11;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  // The divider retires this many quotient bits per cycle.
  localparam int DIV_STEP   = 3;
  localparam int DIV_CYCLES = (IDX_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
  localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NB_COUNT - 1);

  typedef enum logic [1:0] {
    OFF_ZERO,
    OFF_PLUS,
    OFF_MINUS
  } off_t;

  typedef enum logic [1:0] {
    REG_ROW_COUNT    = 2'd0,
    REG_COLUMN_COUNT = 2'd1,
    REG_COLUMN_MAJOR = 2'd2
  } reg_idx_t;

  localparam off_t RING_DROW [NB_COUNT] = '{
    OFF_MINUS, OFF_MINUS, OFF_MINUS, OFF_ZERO,
    OFF_PLUS,  OFF_PLUS,  OFF_PLUS,  OFF_ZERO
  };

  localparam off_t RING_DCOL [NB_COUNT] = '{
    OFF_MINUS, OFF_ZERO,  OFF_PLUS,  OFF_PLUS,
    OFF_PLUS,  OFF_ZERO,  OFF_MINUS, OFF_MINUS
  };

endpackage

// ----- hdl/gni_front.sv -----
module gni_front #(
  parameter int EW = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [gni_pkg::IDX_W-1:0] in_node_index,
  input  logic [EW-1:0]             divisor,
  output logic                      push_valid,
  input  logic                      push_ready,
  output logic [gni_pkg::IDX_W-1:0] push_quot,
  output logic [EW-1:0]             push_rem
);

  logic                      busy_r;
  logic                      busy_nxt;
  logic [gni_pkg::CNT_W-1:0] cnt_r;
  logic [gni_pkg::CNT_W-1:0] cnt_nxt;
  logic [gni_pkg::DIV_W-1:0] dvd_r;
  logic [gni_pkg::DIV_W-1:0] dvd_nxt;
  logic [EW-1:0]             rem_r;
  logic [EW-1:0]             rem_nxt;
  logic [EW:0]               trial;
  logic                      done;
  logic                      accept;

  assign done       = busy_r && (cnt_r == gni_pkg::CNT_W'(gni_pkg::DIV_CYCLES));
  assign push_valid = done;
  assign in_ready   = !busy_r || (done && push_ready);
  assign accept     = in_valid && in_ready;
  assign push_quot  = dvd_r[gni_pkg::IDX_W-1:0];
  assign push_rem   = rem_r;

  // Restoring division: the dividend shifts out at the top while the
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    trial   = '0;
    for (int i = 0; i < gni_pkg::DIV_STEP; i++) begin
      trial   = {rem_nxt, dvd_nxt[gni_pkg::DIV_W-1]};
      dvd_nxt = {dvd_nxt[gni_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial      = trial - {1'b0, divisor};
        dvd_nxt[0] = 1'b1;
      end
      rem_nxt = trial[EW-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (done && push_ready) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !done) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dvd_r <= gni_pkg::DIV_W'(in_node_index);
      rem_r <= '0;
    end else if (busy_r && !done) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ----- hdl/gni_queue.sv -----
module gni_queue #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0]                mem_r [gni_pkg::Q_DEPTH];
  logic [gni_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [gni_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [gni_pkg::Q_CNT_W-1:0] count_r;
  logic [gni_pkg::Q_CNT_W-1:0] count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign push_ready = count_r != gni_pkg::Q_CNT_W'(gni_pkg::Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/gni_back.sv -----
module gni_back #(
  parameter int EW = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  logic [gni_pkg::IDX_W-1:0]  quot,
  input  logic [EW-1:0]              rem,
  input  logic [EW-1:0]              inner_ext,
  input  logic [EW-1:0]              outer_ext,
  input  logic                       column_major,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gni_pkg::SLOT_W-1:0] out_neighbour_slot,
  output logic                       out_in_bounds,
  output logic [gni_pkg::IDX_W-1:0]  out_neighbour_index,
  output logic                       out_last_neighbour
);

  localparam int SW = 2 * EW + 1;
  localparam int IW = (SW > gni_pkg::IDX_W) ? SW : gni_pkg::IDX_W;

  logic [gni_pkg::SLOT_W-1:0] slot_r;
  logic [gni_pkg::SLOT_W-1:0] slot_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [gni_pkg::SLOT_W-1:0] slot_out_r;
  logic                       in_bounds_r;
  logic [gni_pkg::IDX_W-1:0]  index_r;
  logic                       last_r;
  logic                       adv;
  gni_pkg::off_t              off_a;
  gni_pkg::off_t              off_b;
  logic [gni_pkg::IDX_W:0]    na;
  logic [EW:0]                nb;
  logic                       a_low;
  logic                       b_low;
  logic                       in_grid;
  logic [2*EW-1:0]            prod;
  logic [IW-1:0]              sum;
  logic [gni_pkg::IDX_W-1:0]  index_nxt;

  assign adv       = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready = adv && (slot_r == gni_pkg::SLOT_LAST);

  // The quotient is the outer coordinate and the remainder the inner one,
  // so in column-major order the row and column offsets trade places.
  always_comb begin
    off_a = column_major ? gni_pkg::RING_DCOL[slot_r] : gni_pkg::RING_DROW[slot_r];
    off_b = column_major ? gni_pkg::RING_DROW[slot_r] : gni_pkg::RING_DCOL[slot_r];

    case (off_a)
      gni_pkg::OFF_PLUS: begin
        na    = {1'b0, quot} + 1'b1;
        a_low = 1'b0;
      end
      gni_pkg::OFF_MINUS: begin
        na    = {1'b0, quot} - 1'b1;
        a_low = (quot == '0);
      end
      default: begin
        na    = {1'b0, quot};
        a_low = 1'b0;
      end
    endcase

    case (off_b)
      gni_pkg::OFF_PLUS: begin
        nb    = {1'b0, rem} + 1'b1;
        b_low = 1'b0;
      end
      gni_pkg::OFF_MINUS: begin
        nb    = {1'b0, rem} - 1'b1;
        b_low = (rem == '0);
      end
      default: begin
        nb    = {1'b0, rem};
        b_low = 1'b0;
      end
    endcase

    in_grid = !a_low && (na < (gni_pkg::IDX_W + 1)'(outer_ext)) &&
              !b_low && (nb < {1'b0, inner_ext});
    prod      = inner_ext * na[EW-1:0];
    sum       = IW'(prod) + IW'(nb[EW-1:0]);
    index_nxt = in_grid ? sum[gni_pkg::IDX_W-1:0] : '0;
  end

  always_comb begin
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      slot_nxt      = slot_r + 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot_out_r  <= slot_r;
      in_bounds_r <= in_grid;
      index_r     <= index_nxt;
      last_r      <= (slot_r == gni_pkg::SLOT_LAST);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_neighbour_slot  = slot_out_r;
  assign out_in_bounds       = in_bounds_r;
  assign out_neighbour_index = index_r;
  assign out_last_neighbour  = last_r;

endmodule

// ----- hdl/grid_eight_neighbour_indexer.sv -----
// Path: each input passes through the divider, the queue and the output register of the back end;
// after its first result the other seven follow on consecutive cycles when out_ready stays high.
// Input rate: bounded by the eight results per input and by the divider, which retires
// 3 quotient bits per cycle and takes a new input as it hands its result to the queue.
// Reset: synchronous, active low; clears the control state and sets the extents to 1
// and the storage order to row major. There is no clearing pass.
module grid_eight_neighbour_indexer #(
  parameter int MAX_EXTENT = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gni_pkg::IDX_W-1:0]   in_node_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gni_pkg::SLOT_W-1:0]  out_neighbour_slot,
  output logic                        out_in_bounds,
  output logic [gni_pkg::IDX_W-1:0]   out_neighbour_index,
  output logic                        out_last_neighbour,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gni_pkg::APB_AW-1:0]  paddr,
  input  logic [gni_pkg::APB_DW-1:0]  pwdata,
  output logic [gni_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int EW = $clog2(MAX_EXTENT + 1);
  localparam int QW = gni_pkg::IDX_W + EW;

  logic [gni_pkg::CFG_W-1:0] row_count_r;
  logic [gni_pkg::CFG_W-1:0] column_count_r;
  logic                      column_major_r;
  logic                      cfg_wr;
  gni_pkg::reg_idx_t         reg_idx;
  logic [EW-1:0]             rows_ext;
  logic [EW-1:0]             cols_ext;
  logic [EW-1:0]             inner_ext;
  logic [EW-1:0]             outer_ext;
  logic                      push_valid;
  logic                      push_ready;
  logic [gni_pkg::IDX_W-1:0] push_quot;
  logic [EW-1:0]             push_rem;
  logic                      pop_valid;
  logic                      pop_ready;
  logic [QW-1:0]             pop_data;

  function automatic logic [EW-1:0] clamp_ext(input logic [gni_pkg::CFG_W-1:0] v);
    logic [EW-1:0] res;
    if (v == '0) begin
      res = EW'(1);
    end else if (32'(v) > 32'(MAX_EXTENT)) begin
      res = EW'(MAX_EXTENT);
    end else begin
      res = EW'(v);
    end
    return res;
  endfunction

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = gni_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= gni_pkg::CFG_W'(1);
      column_count_r <= gni_pkg::CFG_W'(1);
      column_major_r <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        gni_pkg::REG_ROW_COUNT: begin
          row_count_r <= pwdata[gni_pkg::CFG_W-1:0];
        end
        gni_pkg::REG_COLUMN_COUNT: begin
          column_count_r <= pwdata[gni_pkg::CFG_W-1:0];
        end
        gni_pkg::REG_COLUMN_MAJOR: begin
          column_major_r <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gni_pkg::REG_ROW_COUNT:    prdata = gni_pkg::APB_DW'(row_count_r);
      gni_pkg::REG_COLUMN_COUNT: prdata = gni_pkg::APB_DW'(column_count_r);
      gni_pkg::REG_COLUMN_MAJOR: prdata = gni_pkg::APB_DW'(column_major_r);
      default:                   prdata = '0;
    endcase
  end

  assign rows_ext  = clamp_ext(row_count_r);
  assign cols_ext  = clamp_ext(column_count_r);
  assign inner_ext = column_major_r ? rows_ext : cols_ext;
  assign outer_ext = column_major_r ? cols_ext : rows_ext;

  gni_front #(
    .EW(EW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_node_index(in_node_index),
    .divisor      (inner_ext),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_quot    (push_quot),
    .push_rem     (push_rem)
  );

  gni_queue #(
    .W(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data ({push_quot, push_rem}),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  gni_back #(
    .EW(EW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .quot               (pop_data[QW-1:EW]),
    .rem                (pop_data[EW-1:0]),
    .inner_ext          (inner_ext),
    .outer_ext          (outer_ext),
    .column_major       (column_major_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_neighbour_slot (out_neighbour_slot),
    .out_in_bounds      (out_in_bounds),
    .out_neighbour_index(out_neighbour_index),
    .out_last_neighbour (out_last_neighbour)
  );

`ifndef ASSERT_OFF
  a_last_on_final_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_neighbour |-> out_neighbour_slot == gni_pkg::SLOT_LAST)
    else $error("last flag on a slot other than the final one");

  a_outside_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_bounds |-> out_neighbour_index == '0)
    else $error("out-of-bounds neighbour with a non-zero index");

  a_divider_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while the divider was still working");

  a_pop_on_final_slot: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && pop_ready |=> out_valid && out_last_neighbour)
    else $error("queue entry released before its eighth result");
`endif

endmodule

// ----- verif/tb_grid_eight_neighbour_indexer.sv -----
module tb_grid_eight_neighbour_indexer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W          = gni_pkg::IDX_W;
  localparam int MAX_EXTENT     = 1024;
  localparam int SETTLE         = 20;
  localparam int RUN_LIMIT      = 600000;
  localparam int RANDOM_GRIDS   = 8;
  localparam int NODES_PER_GRID = 60;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef enum logic [2:0] {
    DIR_NW, DIR_N, DIR_NE, DIR_E, DIR_SE, DIR_S, DIR_SW, DIR_W
  } ring_dir_t;

  typedef struct {
    logic [gni_pkg::SLOT_W-1:0] slot;
    logic                       in_bounds;
    logic [IDX_W-1:0]           index;
    logic                       last;
  } neighbour_t;

  typedef struct {
    logic [10:0]           rows;
    logic [10:0]           cols;
    logic                  col_major;
    logic [IDX_W-1:0]      node;
    bit                    known;
    logic [7:0]            mask;
    logic [0:7][IDX_W-1:0] idx;
  } grid_case_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [IDX_W-1:0]             in_node_index = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [gni_pkg::SLOT_W-1:0]   out_neighbour_slot;
  logic                         out_in_bounds;
  logic [IDX_W-1:0]             out_neighbour_index;
  logic                         out_last_neighbour;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [gni_pkg::APB_AW-1:0]   paddr = '0;
  logic [gni_pkg::APB_DW-1:0]   pwdata = '0;
  logic [gni_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  logic [10:0] grid_rows = 11'd1;
  logic [10:0] grid_cols = 11'd1;
  logic        grid_col_major = 1'b0;

  neighbour_t  neighbour_q[$];
  grid_case_t  corner_cases[$];
  bit          calm = 1'b0;
  int          errors = 0;
  int          nodes_sent = 0;
  int          results_seen = 0;
  int          grids_applied = 0;
  int          cycles = 0;
  int          stall_left = 0;

  grid_eight_neighbour_indexer #(
    .MAX_EXTENT(MAX_EXTENT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_node_index(in_node_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_neighbour_slot(out_neighbour_slot),
    .out_in_bounds(out_in_bounds),
    .out_neighbour_index(out_neighbour_index),
    .out_last_neighbour(out_last_neighbour),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic int eff_extent(logic [10:0] v);
    if (v == 11'd0) return 1;
    if (v > MAX_EXTENT) return MAX_EXTENT;
    return int'(v);
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [10:0] pick_extent();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 11'd1024;
    if (roll == 1) return $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1025, 2047));
    if (roll == 2) return 11'd1;
    return 11'($urandom_range(2, 24));
  endfunction

  function automatic logic [IDX_W-1:0] pick_node();
    int rows;
    int cols;
    int area;
    int hi;
    int roll;
    rows = eff_extent(grid_rows);
    cols = eff_extent(grid_cols);
    area = rows * cols;
    roll = $urandom_range(0, 99);
    if (roll < 70) return IDX_W'($urandom_range(0, area - 1));
    if (roll < 85 && area <= 'hFFFFF) begin
      hi = area + 2 * (rows + cols);
      if (hi > 'hFFFFF) hi = 'hFFFFF;
      return IDX_W'($urandom_range(area, hi));
    end
    return IDX_W'($urandom());
  endfunction

  // Splits the centre into row and column and queues the eight neighbours in ring order.
  function automatic void predict_ring(logic [IDX_W-1:0] node, bit known, logic [7:0] mask,
                                       logic [0:7][IDX_W-1:0] idx);
    int rows;
    int cols;
    int lin;
    int r;
    int c;
    int dr;
    int dc;
    int nr;
    int nc;
    bit hit;
    neighbour_t nb;
    rows = eff_extent(grid_rows);
    cols = eff_extent(grid_cols);
    lin = int'(node);
    if (grid_col_major) begin
      r = lin % rows;
      c = lin / rows;
    end else begin
      r = lin / cols;
      c = lin % cols;
    end
    for (int k = 0; k < gni_pkg::NB_COUNT; k++) begin
      case (k)
        DIR_NW: begin dr = -1; dc = -1; end
        DIR_N:  begin dr = -1; dc = 0;  end
        DIR_NE: begin dr = -1; dc = 1;  end
        DIR_E:  begin dr = 0;  dc = 1;  end
        DIR_SE: begin dr = 1;  dc = 1;  end
        DIR_S:  begin dr = 1;  dc = 0;  end
        DIR_SW: begin dr = 1;  dc = -1; end
        default: begin dr = 0; dc = -1; end
      endcase
      nr = r + dr;
      nc = c + dc;
      hit = nr >= 0 && nr < rows && nc >= 0 && nc < cols;
      nb.slot = gni_pkg::SLOT_W'(k);
      nb.in_bounds = hit;
      if (!hit) nb.index = '0;
      else if (grid_col_major) nb.index = IDX_W'(rows * nc + nr);
      else nb.index = IDX_W'(cols * nr + nc);
      nb.last = (k == DIR_W);
      if (known) begin
        nb.in_bounds = mask[k];
        nb.index = idx[k];
      end
      neighbour_q.push_back(nb);
    end
  endfunction

  task automatic add_case(logic [10:0] rows, logic [10:0] cols, logic col_major,
                          logic [IDX_W-1:0] node, bit known, logic [7:0] mask,
                          logic [0:7][IDX_W-1:0] idx);
    grid_case_t gc;
    gc.rows = rows;
    gc.cols = cols;
    gc.col_major = col_major;
    gc.node = node;
    gc.known = known;
    gc.mask = mask;
    gc.idx = idx;
    corner_cases.push_back(gc);
  endtask

  task automatic write_reg(logic [1:0] reg_sel, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_sel)
      gni_pkg::REG_ROW_COUNT:    grid_rows = data[10:0];
      gni_pkg::REG_COLUMN_COUNT: grid_cols = data[10:0];
      gni_pkg::REG_COLUMN_MAJOR: grid_col_major = data[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_grid(logic [10:0] rows, logic [10:0] cols, logic col_major);
    in_valid <= 1'b0;
    while (neighbour_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(gni_pkg::REG_ROW_COUNT, ($urandom() & 32'hFFFF_F800) | 32'(rows));
    write_reg(REG_SPARE, $urandom());
    write_reg(gni_pkg::REG_COLUMN_COUNT, ($urandom() & 32'hFFFF_F800) | 32'(cols));
    write_reg(gni_pkg::REG_COLUMN_MAJOR, ($urandom() & 32'hFFFF_FFFE) | 32'(col_major));
    grids_applied++;
  endtask

  task automatic send_node(logic [IDX_W-1:0] node, bit known, logic [7:0] mask,
                           logic [0:7][IDX_W-1:0] idx);
    int gap;
    if (!in_valid) in_valid <= 1'b1;
    in_node_index <= node;
    do @(posedge clk); while (!in_ready);
    predict_ring(node, known, mask, idx);
    nodes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : ready_gen
    int roll;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) stall_left = $urandom_range(1, 3);
        else if (roll < 23) stall_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin : result_check
    neighbour_t want;
    if (rst_n && out_valid && out_ready) begin
      if (neighbour_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, slot %0d index %0d", $time,
                 out_neighbour_slot, out_neighbour_index);
      end else begin
        want = neighbour_q.pop_front();
        results_seen++;
        if (out_neighbour_slot !== want.slot) begin
          errors++;
          $display("%0t: slot expected %0d got %0d", $time, want.slot, out_neighbour_slot);
        end
        if (out_in_bounds !== want.in_bounds) begin
          errors++;
          $display("%0t: in_bounds (slot %0d) expected %0d got %0d", $time, want.slot,
                   want.in_bounds, out_in_bounds);
        end
        if (out_neighbour_index !== want.index) begin
          errors++;
          $display("%0t: index (slot %0d) expected %0d got %0d", $time, want.slot,
                   want.index, out_neighbour_index);
        end
        if (out_last_neighbour !== want.last) begin
          errors++;
          $display("%0t: last (slot %0d) expected %0d got %0d", $time, want.slot,
                   want.last, out_last_neighbour);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("tb_grid_eight_neighbour_indexer: done, errors");
      $finish;
    end
  end

  initial begin
    grid_case_t gc;
    add_case(11'd1, 11'd1, 1'b0, 20'd0, 1'b1, 8'b0000_0000, '0);
    add_case(11'd1, 11'd1, 1'b0, 20'hFFFFF, 1'b1, 8'b0000_0000, '0);
    add_case(11'd1, 11'd1, 1'b0, 20'h55555, 1'b0, '0, '0);
    add_case(11'd1, 11'd1, 1'b0, 20'hAAAAA, 1'b0, '0, '0);
    add_case(11'd3, 11'd3, 1'b0, 20'd4, 1'b1, 8'b1111_1111,
             {20'd0, 20'd1, 20'd2, 20'd5, 20'd8, 20'd7, 20'd6, 20'd3});
    add_case(11'd3, 11'd3, 1'b0, 20'd0, 1'b1, 8'b0011_1000,
             {20'd0, 20'd0, 20'd0, 20'd1, 20'd4, 20'd3, 20'd0, 20'd0});
    add_case(11'd3, 11'd3, 1'b0, 20'd8, 1'b1, 8'b1000_0011,
             {20'd4, 20'd5, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd7});
    add_case(11'd3, 11'd3, 1'b0, 20'd9, 1'b1, 8'b0000_0110,
             {20'd0, 20'd6, 20'd7, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0});
    add_case(11'd3, 11'd3, 1'b1, 20'd1, 1'b1, 8'b0011_1110,
             {20'd0, 20'd0, 20'd3, 20'd4, 20'd5, 20'd2, 20'd0, 20'd0});
    add_case(11'd3, 11'd3, 1'b1, 20'd5, 1'b0, '0, '0);
    add_case(11'd1024, 11'd1024, 1'b0, 20'hFFFFF, 1'b1, 8'b1000_0011,
             {20'd1047550, 20'd1047551, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd1048574});
    add_case(11'd1024, 11'd1024, 1'b0, 20'd0, 1'b0, '0, '0);
    add_case(11'd1024, 11'd1024, 1'b0, 20'h80000, 1'b0, '0, '0);
    add_case(11'd1024, 11'd1024, 1'b0, 20'h7FFFF, 1'b0, '0, '0);
    add_case(11'd1024, 11'd1024, 1'b1, 20'hFFFFF, 1'b0, '0, '0);
    add_case(11'd1024, 11'd1024, 1'b1, 20'd1023, 1'b0, '0, '0);
    add_case(11'd0, 11'd2047, 1'b0, 20'd5, 1'b0, '0, '0);
    add_case(11'd0, 11'd2047, 1'b0, 20'd1024, 1'b0, '0, '0);
    add_case(11'd0, 11'd2047, 1'b0, 20'hFFFFF, 1'b0, '0, '0);
    add_case(11'd2047, 11'd0, 1'b1, 20'd3, 1'b0, '0, '0);
    add_case(11'd2047, 11'd0, 1'b1, 20'd1024, 1'b0, '0, '0);
    add_case(11'd1025, 11'd1, 1'b0, 20'd7, 1'b0, '0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_cases[i]) begin
      gc = corner_cases[i];
      if (gc.rows != grid_rows || gc.cols != grid_cols || gc.col_major != grid_col_major)
        apply_grid(gc.rows, gc.cols, gc.col_major);
      send_node(gc.node, gc.known, gc.mask, gc.idx);
    end

    for (int g = 0; g < RANDOM_GRIDS; g++) begin
      apply_grid(pick_extent(), pick_extent(), 1'($urandom_range(0, 1)));
      calm = (g % 3 == 2);
      for (int n = 0; n < NODES_PER_GRID; n++)
        send_node(pick_node(), 1'b0, '0, '0);
    end

    in_valid <= 1'b0;
    while (neighbour_q.size() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);

    $display("Sent %0d centre nodes over %0d grid shapes, %0d neighbour results compared.",
             nodes_sent, grids_applied, results_seen);
    $display("Included grid corners, outside centres, clamped extents and both orders.");
    if (errors == 0) begin
      $display("tb_grid_eight_neighbour_indexer: done, clean");
    end else begin
      $display("tb_grid_eight_neighbour_indexer: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/gni_pkg.sv
hdl/gni_front.sv
hdl/gni_queue.sv
hdl/gni_back.sv
hdl/grid_eight_neighbour_indexer.sv
verif/tb_grid_eight_neighbour_indexer.sv
